/* src/ffa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_pkg : shared types and constants of the first-fit heap allocator
// Block header layout, request/result words, status codes and FSM states.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int GRAN_BITS   = 4;                 // 16-byte granule
    localparam int HDR_BYTES   = 32;                // header size, granule multiple
    localparam int MIN_PAYLOAD = 32;
    localparam int HEAP_MAX    = 65536;
    localparam int CFG_FLOOR   = 1024;
    localparam int SLOT_BITS   = 12;
    localparam int SLOTS       = 1 << SLOT_BITS;
    localparam int OFF_W       = 17;                // byte offset incl. heap end
    localparam int SIZE_W      = 16;                // payload size of one block

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_REALLOC = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OOM       = 3'd1;
    localparam logic [2:0] ST_ZERO      = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_DOUBLE    = 3'd4;
    localparam logic [2:0] ST_NOT_BLOCK = 3'd5;

    typedef struct packed {
        logic                 mark;      // a live block starts here
        logic                 is_free;
        logic                 has_prev;
        logic [SLOT_BITS-1:0] prev;      // granule of previous block
        logic [SIZE_W-1:0]    size;      // payload bytes
    } hdr_t;

    localparam int HDR_W = $bits(hdr_t);

    typedef struct packed {
        logic [1:0]  req_type;
        logic [16:0] req_size;
        logic [15:0] req_addr;
        logic        req_addr_null;
    } req_t;

    typedef struct packed {
        logic [15:0] result_addr;
        logic        result_null;
        logic [2:0]  status;
        logic [16:0] copy_bytes;
        logic [15:0] freed_addr;
    } res_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_WALK_RD,
        S_WALK_CHK,
        S_TAKE,
        S_TAKE_WH,
        S_LOC_RD,
        S_LOC_CHK,
        S_RE_N_RD,
        S_RE_N_CHK,
        S_RE_WH,
        S_REL_RD,
        S_REL_H,
        S_REL_N_RD,
        S_REL_N_CHK,
        S_REL_WH,
        S_REL_P_RD,
        S_REL_P_CHK,
        S_REL_BCLR,
        S_SP_RD,
        S_SP_CHK,
        S_DONE
    } state_t;

    function automatic logic [SLOT_BITS-1:0] gran_of(input logic [OFF_W-1:0] off);
        return off[SLOT_BITS+GRAN_BITS-1:GRAN_BITS];
    endfunction

endpackage
`default_nettype wire

/* src/ffa_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_ram : generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* src/ffa_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ffa_ctrl : allocator sequencer
// Walks, splits and merges block headers held in the header RAM.
// ----------------------------------------------------------------------------
module ffa_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [16:0]          heap_cfg,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire ffa_pkg::req_t        req,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output ffa_pkg::res_t             res,
    output logic                      mem_we,
    output logic [ffa_pkg::SLOT_BITS-1:0] mem_waddr,
    output ffa_pkg::hdr_t             mem_wdata,
    output logic [ffa_pkg::SLOT_BITS-1:0] mem_raddr,
    input  wire ffa_pkg::hdr_t        mem_rdata
);
    import ffa_pkg::*;

    localparam logic [OFF_W-1:0] HDR_OFF = OFF_W'(HDR_BYTES);

    state_t               state_reg, state_next;
    logic [SLOT_BITS-1:0] clr_reg, clr_next;
    logic                 ready_reg, ready_next;
    logic [OFF_W-1:0]     total_reg, total_next;
    req_t                 req_reg, req_next;
    logic                 move_reg, move_next;
    logic [OFF_W-1:0]     cur_reg, cur_next;
    logic [OFF_W-1:0]     b_reg, b_next;
    logic [OFF_W-1:0]     nx_reg, nx_next;
    hdr_t                 h_reg, h_next;
    logic [OFF_W-1:0]     asize_reg, asize_next;
    logic [SLOT_BITS-1:0] sp_prev_reg, sp_prev_next;
    state_t               sp_ret_reg, sp_ret_next;
    res_t                 res_reg, res_next;

    logic [OFF_W:0]   size_wide;
    logic [OFF_W-1:0] size_rnd, asize_calc, cfg_clamp, cfg_total;
    logic [OFF_W-1:0] p_off, merged_size, p_size;
    logic             is_re, nx_live, cur_live, p_live, split_ok;

    // request decode and arithmetic shared by the states
    assign is_re      = (req_reg.req_type == REQ_REALLOC) && (req_reg.req_size != '0);
    // saturate sizes beyond the offset range: they can never fit a block
    assign size_wide  = ({1'b0, req_reg.req_size} + 18'd15) & ~18'd15;
    assign size_rnd   = size_wide[OFF_W] ? {OFF_W{1'b1}} : size_wide[OFF_W-1:0];
    assign asize_calc = (size_rnd < OFF_W'(MIN_PAYLOAD)) ? OFF_W'(MIN_PAYLOAD) : size_rnd;

    always_comb
    begin
        cfg_clamp = heap_cfg;
        if (heap_cfg < OFF_W'(CFG_FLOOR))
        begin
            cfg_clamp = OFF_W'(CFG_FLOOR);
        end
        else if (heap_cfg > OFF_W'(HEAP_MAX))
        begin
            cfg_clamp = OFF_W'(HEAP_MAX);
        end
    end
    assign cfg_total = (cfg_clamp + 17'd15) & ~17'd15;

    assign cur_live    = (cur_reg < total_reg) && mem_rdata.mark;
    assign nx_live     = (nx_reg < total_reg) && mem_rdata.mark;
    assign p_off       = {1'b0, h_reg.prev, {GRAN_BITS{1'b0}}};
    assign p_live      = (p_off < total_reg) && mem_rdata.mark && mem_rdata.is_free;
    assign merged_size = OFF_W'(h_reg.size) + HDR_OFF + OFF_W'(mem_rdata.size);
    assign p_size      = OFF_W'(mem_rdata.size) + HDR_OFF + OFF_W'(h_reg.size);
    assign split_ok    = {2'b0, h_reg.size} >= ({1'b0, asize_reg} + 18'd64);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (&clr_reg) state_next = S_IDLE;
            S_IDLE:     if (req_valid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                priority if (req_reg.req_type == REQ_ALLOC)
                    state_next = S_ALLOC;
                else if ((req_reg.req_type == REQ_REALLOC) && req_reg.req_addr_null)
                    state_next = S_ALLOC;
                else if ((req_reg.req_type == REQ_FREE) ||
                         (req_reg.req_type == REQ_REALLOC))
                begin
                    priority if (req_reg.req_addr_null)
                        state_next = S_DONE;
                    else if (!ready_reg || ({1'b0, req_reg.req_addr} >= total_reg))
                        state_next = S_DONE;
                    else if ((req_reg.req_addr < 16'(HDR_BYTES)) ||
                             (req_reg.req_addr[GRAN_BITS-1:0] != '0))
                        state_next = S_DONE;
                    else
                        state_next = S_LOC_RD;
                end
                else
                    state_next = S_DONE;
            end
            S_ALLOC:    state_next = (req_reg.req_size == '0) ? S_DONE : S_WALK_RD;
            S_WALK_RD:  state_next = S_WALK_CHK;
            S_WALK_CHK:
            begin
                priority if (!cur_live)
                    state_next = S_DONE;
                else if (mem_rdata.is_free && (OFF_W'(mem_rdata.size) >= asize_reg))
                    state_next = S_TAKE;
                else
                    state_next = S_WALK_RD;
            end
            S_TAKE:     state_next = split_ok ? S_SP_RD : S_TAKE_WH;
            S_TAKE_WH:  state_next = move_reg ? S_REL_RD : S_DONE;
            S_LOC_RD:   state_next = S_LOC_CHK;
            S_LOC_CHK:
            begin
                priority if (!mem_rdata.mark || mem_rdata.is_free)
                    state_next = S_DONE;
                else if (!is_re)
                    state_next = S_REL_N_RD;
                else if (OFF_W'(mem_rdata.size) >= asize_reg)
                    state_next = S_DONE;
                else
                    state_next = S_RE_N_RD;
            end
            S_RE_N_RD:  state_next = S_RE_N_CHK;
            S_RE_N_CHK:
            begin
                if (nx_live && mem_rdata.is_free && (merged_size >= asize_reg))
                    state_next = S_RE_WH;
                else
                    state_next = S_ALLOC;
            end
            S_RE_WH:    state_next = S_SP_RD;
            S_REL_RD:   state_next = S_REL_H;
            S_REL_H:    state_next = S_REL_N_RD;
            S_REL_N_RD: state_next = S_REL_N_CHK;
            S_REL_N_CHK:
                state_next = (nx_live && mem_rdata.is_free) ? S_SP_RD : S_REL_WH;
            S_REL_WH:   state_next = h_reg.has_prev ? S_REL_P_RD : S_DONE;
            S_REL_P_RD: state_next = S_REL_P_CHK;
            S_REL_P_CHK: state_next = p_live ? S_REL_BCLR : S_DONE;
            S_REL_BCLR: state_next = S_SP_RD;
            S_SP_RD:    state_next = S_SP_CHK;
            S_SP_CHK:   state_next = sp_ret_reg;
            S_DONE:     if (res_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // memory port and handshake outputs
    always_comb
    begin
        req_ready = (state_reg == S_IDLE);
        res_valid = (state_reg == S_DONE);
        res       = res_reg;
        mem_we    = 1'b0;
        mem_waddr = gran_of(b_reg);
        mem_wdata = h_reg;
        mem_raddr = gran_of(nx_reg);
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            S_ALLOC:
            begin
                mem_we            = !ready_reg && (req_reg.req_size != '0);
                mem_waddr         = '0;
                mem_wdata         = '0;
                mem_wdata.mark    = 1'b1;
                mem_wdata.is_free = 1'b1;
                mem_wdata.size    = SIZE_W'(cfg_total - HDR_OFF);
            end
            S_WALK_RD:  mem_raddr = gran_of(cur_reg);
            S_TAKE:
            begin
                mem_we             = split_ok;
                mem_waddr          = gran_of(cur_reg + HDR_OFF + asize_reg);
                mem_wdata.mark     = 1'b1;
                mem_wdata.is_free  = 1'b1;
                mem_wdata.has_prev = 1'b1;
                mem_wdata.prev     = gran_of(cur_reg);
                mem_wdata.size     = SIZE_W'(OFF_W'(h_reg.size) - asize_reg - HDR_OFF);
            end
            S_TAKE_WH:
            begin
                mem_we            = 1'b1;
                mem_waddr         = gran_of(cur_reg);
                mem_wdata.is_free = 1'b0;
            end
            S_LOC_RD, S_REL_RD: mem_raddr = gran_of(b_reg);
            S_RE_N_CHK, S_REL_N_CHK:
            begin
                mem_we         = nx_live && mem_rdata.is_free &&
                                 ((state_reg == S_REL_N_CHK) || (merged_size >= asize_reg));
                mem_waddr      = gran_of(nx_reg);
                mem_wdata      = mem_rdata;
                mem_wdata.mark = 1'b0;
            end
            S_RE_WH:    mem_we = 1'b1;
            S_REL_WH:
            begin
                mem_we            = 1'b1;
                mem_wdata.is_free = 1'b1;
            end
            S_REL_P_RD: mem_raddr = h_reg.prev;
            S_REL_P_CHK:
            begin
                mem_we         = p_live;
                mem_waddr      = h_reg.prev;
                mem_wdata      = mem_rdata;
                mem_wdata.size = SIZE_W'(p_size);
            end
            S_REL_BCLR:
            begin
                mem_we         = 1'b1;
                mem_wdata.mark = 1'b0;
            end
            S_SP_CHK:
            begin
                mem_we             = nx_live;
                mem_waddr          = gran_of(nx_reg);
                mem_wdata          = mem_rdata;
                mem_wdata.prev     = sp_prev_reg;
                mem_wdata.has_prev = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // working registers
    always_comb
    begin
        clr_next     = clr_reg;
        ready_next   = ready_reg;
        total_next   = total_reg;
        req_next     = req_reg;
        move_next    = move_reg;
        cur_next     = cur_reg;
        b_next       = b_reg;
        nx_next      = nx_reg;
        h_next       = h_reg;
        asize_next   = asize_reg;
        sp_prev_next = sp_prev_reg;
        sp_ret_next  = sp_ret_reg;
        res_next     = res_reg;
        unique case (state_reg)
            S_CLEAR:    clr_next = clr_reg + 1'b1;
            S_IDLE:     if (req_valid) req_next = req;
            S_DISPATCH:
            begin
                move_next            = 1'b0;
                asize_next           = asize_calc;
                b_next               = OFF_W'(req_reg.req_addr) - HDR_OFF;
                res_next             = '0;
                res_next.result_null = 1'b1;
                if (!ready_reg || ({1'b0, req_reg.req_addr} >= total_reg))
                    res_next.status = ST_OUTSIDE;
                else if ((req_reg.req_addr < 16'(HDR_BYTES)) ||
                         (req_reg.req_addr[GRAN_BITS-1:0] != '0))
                    res_next.status = ST_NOT_BLOCK;
                if (req_reg.req_addr_null || (req_reg.req_type == REQ_ALLOC) ||
                    (req_reg.req_type == REQ_UNUSED))
                    res_next.status = ST_OK;
            end
            S_ALLOC:
            begin
                cur_next = '0;
                if (req_reg.req_size == '0)
                begin
                    res_next.status = ST_ZERO;
                end
                else if (!ready_reg)
                begin
                    ready_next = 1'b1;
                    total_next = cfg_total;
                end
            end
            S_WALK_CHK:
            begin
                h_next   = mem_rdata;
                cur_next = cur_reg + HDR_OFF + OFF_W'(mem_rdata.size);
                if (!cur_live)
                begin
                    res_next        = '0;
                    res_next.result_null = 1'b1;
                    res_next.status = ST_OOM;
                end
                else if (mem_rdata.is_free && (OFF_W'(mem_rdata.size) >= asize_reg))
                begin
                    cur_next = cur_reg;
                end
            end
            S_TAKE:
            begin
                nx_next      = cur_reg + HDR_OFF + OFF_W'(h_reg.size);
                sp_prev_next = gran_of(cur_reg + HDR_OFF + asize_reg);
                sp_ret_next  = S_TAKE_WH;
                if (split_ok)
                    h_next.size = SIZE_W'(asize_reg);
            end
            S_TAKE_WH:
            begin
                res_next.result_addr = 16'(cur_reg + HDR_OFF);
                res_next.result_null = 1'b0;
                res_next.status      = ST_OK;
            end
            S_LOC_CHK:
            begin
                h_next  = mem_rdata;
                nx_next = b_reg + HDR_OFF + OFF_W'(mem_rdata.size);
                if (!mem_rdata.mark)
                    res_next.status = ST_NOT_BLOCK;
                else if (mem_rdata.is_free)
                    res_next.status = ST_DOUBLE;
                else if (is_re && (OFF_W'(mem_rdata.size) >= asize_reg))
                begin
                    res_next.result_addr = req_reg.req_addr;
                    res_next.result_null = 1'b0;
                end
            end
            S_RE_N_CHK:
            begin
                if (nx_live && mem_rdata.is_free && (merged_size >= asize_reg))
                begin
                    h_next.size = SIZE_W'(merged_size);
                    nx_next     = b_reg + HDR_OFF + merged_size;
                end
                else
                begin
                    move_next           = 1'b1;
                    res_next.copy_bytes = (OFF_W'(h_reg.size) < asize_reg) ?
                                          OFF_W'(h_reg.size) : asize_reg;
                    res_next.freed_addr = req_reg.req_addr;
                end
            end
            S_RE_WH:
            begin
                sp_prev_next         = gran_of(b_reg);
                sp_ret_next          = S_DONE;
                res_next.result_addr = req_reg.req_addr;
                res_next.result_null = 1'b0;
            end
            S_REL_H:
            begin
                h_next  = mem_rdata;
                nx_next = b_reg + HDR_OFF + OFF_W'(mem_rdata.size);
            end
            S_REL_N_CHK:
            begin
                h_next.is_free = 1'b1;
                if (nx_live && mem_rdata.is_free)
                begin
                    h_next.size  = SIZE_W'(merged_size);
                    nx_next      = b_reg + HDR_OFF + merged_size;
                    sp_prev_next = gran_of(b_reg);
                    sp_ret_next  = S_REL_WH;
                end
            end
            S_REL_P_CHK:
            begin
                nx_next      = p_off + HDR_OFF + p_size;
                sp_prev_next = h_reg.prev;
                sp_ret_next  = S_DONE;
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ready_reg <= 1'b0;
            total_reg <= '0;
            move_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ready_reg <= ready_next;
            total_reg <= total_next;
            move_reg  <= move_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        cur_reg     <= cur_next;
        b_reg       <= b_next;
        nx_reg      <= nx_next;
        h_reg       <= h_next;
        asize_reg   <= asize_next;
        sp_prev_reg <= sp_prev_next;
        sp_ret_reg  <= sp_ret_next;
        res_reg     <= res_next;
    end

endmodule
`default_nettype wire

/* src/first_fit_heap_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator : first-fit heap manager with split and coalesce
// Serves alloc, free and realloc requests over a heap of address-ordered
// blocks, each with a 32-byte header, kept in one header RAM.
// ----------------------------------------------------------------------------
// One request is served at a time. Every request gives exactly one result
// word. The cost is set by the walk of the header RAM, which has one read
// port and one write port: an alloc grows with the number of blocks visited
// before the first fit, and a split adds to it; a realloc that moves costs
// about an alloc plus a free. The sequencer then returns to idle before the
// next request is taken. After reset a clearing pass sweeps all 4096 header
// slots, during which no request is taken (configuration writes are taken
// at all times). The heap size register is latched by the first alloc;
// later writes take effect only after a reset. The result word sits in an
// output register, so the next request is taken while a finished result
// still waits on the master side.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: heap_bytes_in_use
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [16:0] cfg_data,
    // request stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // req_size[16:0], req_addr[32:17], zero pad
    input  wire logic [2:0]  s_axis_tuser,   // req_type[1:0], req_addr_null[2]
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // result_addr[15:0], status[18:16],
                                             // copy_bytes[35:19], freed_addr[51:36], pad
    output logic [0:0]       m_axis_tuser    // result_null[0]
);
    import ffa_pkg::*;

    logic [16:0] heap_cfg_reg, heap_cfg_next;
    logic        out_valid_reg, out_valid_next;
    res_t        out_reg, out_next;

    req_t        req;
    res_t        res;
    logic        res_valid, res_ready;
    logic        mem_we;
    logic [SLOT_BITS-1:0] mem_waddr, mem_raddr;
    hdr_t        mem_wdata, mem_rdata;

    // configuration register: always ready, hold last written value
    assign cfg_ready     = 1'b1;
    assign heap_cfg_next = cfg_valid ? cfg_data : heap_cfg_reg;

    // unpack request word
    assign req.req_type      = s_axis_tuser[1:0];
    assign req.req_addr_null = s_axis_tuser[2];
    assign req.req_size      = s_axis_tdata[16:0];
    assign req.req_addr      = s_axis_tdata[32:17];

    // output register: advance when empty or being drained
    assign res_ready      = !out_valid_reg || m_axis_tready;
    assign out_valid_next = res_valid || (out_valid_reg && !m_axis_tready);
    assign out_next       = (res_valid && res_ready) ? res : out_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.result_null;
    assign m_axis_tdata  = {4'd0, out_reg.freed_addr, out_reg.copy_bytes,
                            out_reg.status, out_reg.result_addr};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_cfg_reg  <= 17'd65536;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            heap_cfg_reg  <= heap_cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .heap_cfg  (heap_cfg_reg),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ffa_ram #(
        .WIDTH (31),
        .DEPTH (4096)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
`default_nettype wire
